>>> hdl/bce_pkg.sv
// Package for the Bezier curve evaluator: sizes, field types, register indexes,
// command codes and the control structs shared between the block's modules.
// No dependencies.
package bce_pkg;

    // Curve limits.
    localparam int MAX_ORDER = 7;
    localparam int MAX_DIMS  = 4;
    localparam int NPTS      = MAX_ORDER + 1;
    localparam int DEPTH     = NPTS * MAX_DIMS;

    // Index widths.
    localparam int PT_W      = $clog2(NPTS);
    localparam int AX_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = 3;

    // Fixed-point formats.
    localparam int COORD_W   = 32;
    localparam int PARAM_W   = 18;
    localparam int U_W       = 17;
    localparam logic [U_W-1:0] U_ONE = 17'h10000;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 2'd1;
    localparam logic [CNT_W-1:0] CURVE_ORDER_RST = 3'd0;
    localparam logic [CNT_W-1:0] DIMS_IN_USE_RST = 3'd2;

    // Commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [PT_W-1:0]           pt_idx_t;
    typedef logic [AX_W-1:0]           ax_idx_t;
    typedef logic [ADDR_W-1:0]         st_addr_t;

    // Read pipeline tag: one per word read from a memory.
    typedef struct packed {
        logic    vld;
        logic    first;
        logic    src_store;
        pt_idx_t widx;
    } rd_ctl_t;

    // Interpolation unit tag: where its result goes in the work RAM.
    typedef struct packed {
        logic    vld;
        pt_idx_t widx;
    } lerp_ctl_t;

    // Control store address of one coordinate of one point.
    function automatic st_addr_t store_addr(input pt_idx_t pt, input ax_idx_t ax);
        return ADDR_W'(int'(pt) * MAX_DIMS + int'(ax));
    endfunction

endpackage

>>> hdl/bce_if.sv
// Channel interfaces of the Bezier curve evaluator: command, result and
// configuration channels with valid/ready handshakes.
// Depends on bce_pkg.
interface bce_cmd_if;
    import bce_pkg::*;

    logic            valid;
    logic            ready;
    logic            command;
    pt_idx_t         point_index;
    logic [1:0]      axis_index;
    coord_t          write_value;
    logic signed [PARAM_W-1:0] param_u;

    modport source (output valid, command, point_index, axis_index, write_value, param_u,
                    input ready);
    modport sink   (input valid, command, point_index, axis_index, write_value, param_u,
                    output ready);
endinterface

interface bce_res_if;
    import bce_pkg::*;

    logic       valid;
    logic       ready;
    coord_t     point_value;
    logic [1:0] axis_out;
    logic       last;

    modport source (output valid, point_value, axis_out, last, input ready);
    modport sink   (input valid, point_value, axis_out, last, output ready);
endinterface

interface bce_cfg_if;
    import bce_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bce_ctrl_store.sv
// Control point store: one synchronous memory word per point coordinate,
// with a valid bit per entry so that unwritten entries read as zero after reset.
// Depends on bce_pkg.
module bce_ctrl_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  bce_pkg::st_addr_t wr_addr,
    input  bce_pkg::coord_t   wr_data,
    input  bce_pkg::st_addr_t rd_addr,
    output bce_pkg::coord_t   rd_data
);
    import bce_pkg::*;

    coord_t             mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    coord_t             rd_data_reg;
    logic               rd_vld_reg;

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Entry valid bits, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> hdl/bce_work_ram.sv
// Work RAM holding the intermediate points of one de Casteljau pass.
// One write and one registered read per cycle. Depends on bce_pkg.
module bce_work_ram (
    input  logic             clk,
    input  logic             wr_en,
    input  bce_pkg::pt_idx_t wr_addr,
    input  bce_pkg::coord_t  wr_data,
    input  bce_pkg::pt_idx_t rd_addr,
    output bce_pkg::coord_t  rd_data
);
    import bce_pkg::*;

    coord_t mem [NPTS];
    coord_t rd_data_reg;

    // Every entry is written by one pass before the next pass reads it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/bce_lerp.sv
// Shared interpolation unit: a + floor(u*(b-a)/65536), which equals
// floor(((65536-u)*a + u*b)/65536). Multiply stage registered, add after it.
// Depends on bce_pkg.
module bce_lerp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bce_pkg::lerp_ctl_t   ctl_in,
    input  bce_pkg::coord_t      a,
    input  bce_pkg::coord_t      b,
    input  logic [bce_pkg::U_W-1:0] u,
    output bce_pkg::lerp_ctl_t   ctl_out,
    output bce_pkg::coord_t      result
);
    import bce_pkg::*;

    logic signed [COORD_W:0]          diff;
    logic signed [COORD_W+U_W+1:0]    prod_next;
    logic signed [COORD_W+U_W+1:0]    prod_reg;
    logic signed [COORD_W+U_W+1:0]    prod_shr;
    logic signed [COORD_W+1:0]        sum;
    coord_t                           base_reg;
    lerp_ctl_t                        ctl_reg;

    // Difference and product; u is never negative.
    assign diff      = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    assign prod_next = $signed({1'b0, u}) * diff;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        base_reg <= a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Floor shift and final add; the result lies between a and b.
    assign prod_shr = prod_reg >>> 16;
    assign sum      = {{2{base_reg[COORD_W-1]}}, base_reg} + prod_shr[COORD_W+1:0];
    assign result   = sum[COORD_W-1:0];
    assign ctl_out  = ctl_reg;

endmodule

>>> hdl/bezier_curve_evaluator_top.sv
// Bezier curve evaluator top level: configuration registers, command decode,
// de Casteljau sequencer and result register. Depends on bce_pkg, bce_if,
// bce_ctrl_store, bce_work_ram and bce_lerp.
//
//   channel | dir | words carried
//   cmd     | in  | command, point_index, axis_index, write_value, param_u
//   res     | out | point_value, axis_out, last
//   cfg     | in  | index, data (curve_order = 0, dims_in_use = 1)
//
// A write word inside the order and dimension count goes into the store as it is accepted. An
// evaluate word is accepted and then, per dimension, runs one pass per level from the effective
// order (at least one) down to one: each pass streams its points from the store (first pass) or
// the work RAM, then waits for the multiply-add unit to write back.
// Reset clears the control store at once through per-entry valid bits.
// A result waits in its own register; the sequencer stalls only when the next one is done.
module bezier_curve_evaluator_top (
    input  logic      clk,
    input  logic      rst_n,
    bce_cmd_if.sink   cmd,
    bce_res_if.source res,
    bce_cfg_if.sink   cfg
);
    import bce_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]      state_reg, state_next;
    ax_idx_t         dim_reg, dim_next;
    pt_idx_t         lev_reg, lev_next;
    pt_idx_t         rd_reg, rd_next;
    logic            drain_reg, drain_next;
    logic [U_W-1:0]  u_reg, u_next;
    logic [CNT_W-1:0] curve_order_reg, dims_in_use_reg;
    rd_ctl_t         rd1_reg, rd1_next;
    coord_t          a_reg;
    coord_t          last_result_reg;
    logic            out_valid_reg;
    coord_t          point_value_reg;
    ax_idx_t         axis_out_reg;
    logic            last_reg;

    pt_idx_t         eff_order;
    logic [CNT_W-1:0] eff_dims;
    pt_idx_t         top_lev;
    pt_idx_t         rd_pt;
    logic [U_W-1:0]  u_clamp;
    logic            cmd_acc;
    logic            st_wr_en;
    st_addr_t        st_rd_addr;
    coord_t          st_rd_data;
    coord_t          wk_rd_data;
    coord_t          b_data;
    lerp_ctl_t       lerp_in;
    lerp_ctl_t       lerp_out;
    coord_t          lerp_res;
    logic            out_load;

    // Configuration registers: the user writes only while idle; the block never enforces it.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg <= CURVE_ORDER_RST;
            dims_in_use_reg <= DIMS_IN_USE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CURVE_ORDER: curve_order_reg <= cfg.data;
                REG_DIMS_IN_USE: dims_in_use_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Effective order and dimension count, clamped to what the store holds.
    assign eff_order = (int'(curve_order_reg) > MAX_ORDER) ? PT_W'(MAX_ORDER)
                                                           : PT_W'(curve_order_reg);
    assign eff_dims  = (int'(dims_in_use_reg) > MAX_DIMS) ? CNT_W'(MAX_DIMS)
                                                          : dims_in_use_reg;
    // Order zero runs as one pass that blends point 0 with itself.
    assign top_lev   = (eff_order == '0) ? PT_W'(1) : eff_order;

    // Parameter clamp to 0..1.0.
    always_comb
    begin
        if (cmd.param_u[PARAM_W-1])
        begin
            u_clamp = '0;
        end
        else if (cmd.param_u[U_W-1:0] > U_ONE)
        begin
            u_clamp = U_ONE;
        end
        else
        begin
            u_clamp = cmd.param_u[U_W-1:0];
        end
    end

    // Command decode: writes in range go straight into the store.
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign st_wr_en  = cmd_acc && (cmd.command == CMD_WRITE)
                       && (cmd.point_index <= eff_order)
                       && ({1'b0, cmd.axis_index} < eff_dims);

    // Read addresses: the first pass reads the store, later passes the work RAM.
    assign rd_pt      = (rd_reg > eff_order) ? eff_order : rd_reg;
    assign st_rd_addr = store_addr(rd_pt, dim_reg);

    bce_ctrl_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_wr_en),
        .wr_addr (store_addr(cmd.point_index, ax_idx_t'(cmd.axis_index))),
        .wr_data (cmd.write_value),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    bce_work_ram u_work (
        .clk     (clk),
        .wr_en   (lerp_out.vld),
        .wr_addr (lerp_out.widx),
        .wr_data (lerp_res),
        .rd_addr (rd_reg),
        .rd_data (wk_rd_data)
    );

    // Read data stage: the first word of a pass only primes the left operand.
    assign b_data       = rd1_reg.src_store ? st_rd_data : wk_rd_data;
    assign lerp_in.vld  = rd1_reg.vld && !rd1_reg.first;
    assign lerp_in.widx = rd1_reg.widx;

    always_ff @(posedge clk)
    begin
        if (rd1_reg.vld)
        begin
            a_reg <= b_data;
        end
        if (lerp_out.vld)
        begin
            last_result_reg <= lerp_res;
        end
    end

    bce_lerp u_lerp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (lerp_in),
        .a       (a_reg),
        .b       (b_data),
        .u       (u_reg),
        .ctl_out (lerp_out),
        .result  (lerp_res)
    );

    // Read tag for the word requested this cycle.
    always_comb
    begin
        rd1_next.vld       = (state_reg == ST_RUN);
        rd1_next.first     = (rd_reg == '0);
        rd1_next.src_store = (lev_reg == top_lev);
        rd1_next.widx      = rd_reg - PT_W'(1);
    end

    // Result register is free when empty or being taken this cycle.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || res.ready);

    // Sequencer: dimensions high to low, passes from top_lev down to one.
    always_comb
    begin
        state_next = state_reg;
        dim_next   = dim_reg;
        lev_next   = lev_reg;
        rd_next    = rd_reg;
        drain_next = drain_reg;
        u_next     = u_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && (cmd.command == CMD_EVAL) && (eff_dims != '0))
                begin
                    state_next = ST_RUN;
                    dim_next   = AX_W'(eff_dims - CNT_W'(1));
                    lev_next   = top_lev;
                    rd_next    = '0;
                    u_next     = u_clamp;
                end
            end
            ST_RUN:
            begin
                if (rd_reg == lev_reg)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
                else
                begin
                    rd_next = rd_reg + PT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!drain_reg)
                begin
                    drain_next = 1'b1;
                end
                else if (lev_reg == PT_W'(1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_RUN;
                    lev_next   = lev_reg - PT_W'(1);
                    rd_next    = '0;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    if (dim_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        dim_next   = dim_reg - AX_W'(1);
                        lev_next   = top_lev;
                        rd_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dim_reg   <= '0;
            lev_reg   <= '0;
            rd_reg    <= '0;
            drain_reg <= 1'b0;
            u_reg     <= '0;
            rd1_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
            lev_reg   <= lev_next;
            rd_reg    <= rd_next;
            drain_reg <= drain_next;
            u_reg     <= u_next;
            rd1_reg   <= rd1_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            point_value_reg <= last_result_reg;
            axis_out_reg    <= dim_reg;
            last_reg        <= (dim_reg == '0);
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.point_value = point_value_reg;
    assign res.axis_out    = 2'(axis_out_reg);
    assign res.last        = last_reg;

endmodule

>>> tb/sv/bezier_curve_evaluator_top_test.sv
// Self-checking testbench for the Bezier curve evaluator: drives command words,
// predicts every evaluated coordinate with a de Casteljau model of its own.
// Depends on bce_pkg, the bce_if channel interfaces and bezier_curve_evaluator_top.
module bezier_curve_evaluator_top_test;
    import bce_pkg::*;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;
    localparam int     U_FULL    = 65536;
    localparam int     SETTLE_CYCLES = 300;
    localparam int     RUN_LIMIT = 4_000_000;

    // One command word as queued for the driver.
    typedef struct {
        logic                      command;
        pt_idx_t                   point;
        logic [1:0]                axis;
        coord_t                    value;
        logic signed [PARAM_W-1:0] u;
    } curve_cmd_t;

    // One evaluated coordinate as the block should return it.
    typedef struct {
        coord_t     value;
        logic [1:0] axis;
        logic       last;
    } curve_point_t;

    logic clk;
    logic rst_n;

    bce_cmd_if cmd_ch ();
    bce_res_if res_ch ();
    bce_cfg_if cfg_ch ();

    bezier_curve_evaluator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    curve_cmd_t   cmd_backlog[$];
    curve_point_t awaited_points[$];
    curve_cmd_t   next_cmd;
    curve_point_t oldest_point;
    curve_point_t fresh_point;
    logic         cmd_taken;
    int           gap_pct;
    int           stall_pct;
    int           error_count;

    // Shadow copy of the block's control store and registers.
    coord_t           shadow_points [DEPTH];
    logic [CNT_W-1:0] shadow_order;
    logic [CNT_W-1:0] shadow_dims;
    coord_t           lane [NPTS];
    longint           blend_sum;
    int               eff_order;
    int               eff_dims;
    int               u_used;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("TEST FAILED");
        $finish;
    end

    // Command driver: a new word goes out at the falling edge once the last one
    // was taken, unless the sender decides to idle this cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_taken)
        begin
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                next_cmd = cmd_backlog.pop_front();
                cmd_ch.command     <= next_cmd.command;
                cmd_ch.point_index <= next_cmd.point;
                cmd_ch.axis_index  <= next_cmd.axis;
                cmd_ch.write_value <= next_cmd.value;
                cmd_ch.param_u     <= next_cmd.u;
                cmd_ch.valid       <= 1'b1;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls at random according to the current phase.
    always @(negedge clk)
    begin
        res_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: checks results, tracks register writes and predicts each word.
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && cmd_ch.valid && cmd_ch.ready;
        if (rst_n)
        begin
            // Compare a returned coordinate with the oldest prediction.
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_points.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: value %h axis %0d last %0b",
                                 res_ch.point_value, res_ch.axis_out, res_ch.last);
                end
                else
                begin
                    oldest_point = awaited_points.pop_front();
                    if (res_ch.point_value !== oldest_point.value ||
                        res_ch.axis_out !== oldest_point.axis ||
                        res_ch.last !== oldest_point.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                     oldest_point.value, oldest_point.axis,
                                     oldest_point.last, res_ch.point_value,
                                     res_ch.axis_out, res_ch.last);
                    end
                end
            end

            // Register writes; unknown indexes do nothing.
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_CURVE_ORDER: shadow_order = cfg_ch.data;
                    REG_DIMS_IN_USE: shadow_dims  = cfg_ch.data;
                    default: ;
                endcase
            end

            if (cmd_ch.valid && cmd_ch.ready)
            begin
                eff_order = (int'(shadow_order) > MAX_ORDER) ? MAX_ORDER : int'(shadow_order);
                eff_dims  = (int'(shadow_dims) > MAX_DIMS) ? MAX_DIMS : int'(shadow_dims);
                if (cmd_ch.command == CMD_EVAL)
                begin
                    u_used = int'(cmd_ch.param_u);
                    if (u_used < 0)
                        u_used = 0;
                    else if (u_used > U_FULL)
                        u_used = U_FULL;
                    // De Casteljau per dimension, highest dimension first. Each
                    // blend is the floor of the Q16 weighted sum.
                    for (int d = eff_dims - 1; d >= 0; d--)
                    begin
                        for (int i = 0; i <= eff_order; i++)
                            lane[i] = shadow_points[i * MAX_DIMS + d];
                        for (int stage = eff_order; stage > 0; stage--)
                        begin
                            for (int i = 0; i < stage; i++)
                            begin
                                blend_sum = longint'(U_FULL - u_used) * longint'(lane[i])
                                          + longint'(u_used) * longint'(lane[i + 1]);
                                lane[i] = coord_t'(blend_sum >>> 16);
                            end
                        end
                        fresh_point.value = lane[0];
                        fresh_point.axis  = 2'(d);
                        fresh_point.last  = (d == 0);
                        awaited_points.push_back(fresh_point);
                    end
                end
                else if (int'(cmd_ch.point_index) <= eff_order &&
                         int'(cmd_ch.axis_index) < eff_dims)
                begin
                    shadow_points[int'(cmd_ch.point_index) * MAX_DIMS
                                  + int'(cmd_ch.axis_index)] = cmd_ch.write_value;
                end
            end
        end
    end

    // Queue a coordinate write; the curve parameter field carries noise.
    task automatic push_write(input int pt, input int ax, input coord_t value);
        curve_cmd_t item;
        item.command = CMD_WRITE;
        item.point   = pt_idx_t'(pt);
        item.axis    = 2'(ax);
        item.value   = value;
        item.u       = PARAM_W'($urandom());
        cmd_backlog.push_back(item);
    endtask

    // Queue an evaluation; the write fields carry noise.
    task automatic push_eval(input int u);
        curve_cmd_t item;
        item.command = CMD_EVAL;
        item.point   = pt_idx_t'($urandom());
        item.axis    = 2'($urandom());
        item.value   = coord_t'($urandom());
        item.u       = PARAM_W'(u);
        cmd_backlog.push_back(item);
    endtask

    // Write one configuration register and wait for the word to be taken.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every word is taken and every result is back, then let the
    // block finish any evaluation that gives no result.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid || awaited_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus: directed corners first, then random curves in phases of varying idling and stalls.
    initial
    begin
        int order_sel;
        int dims_sel;
        int dims_eff;
        int pt;
        int ax;
        coord_t value;

        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_WRITE;
        cmd_ch.point_index = '0;
        cmd_ch.axis_index  = '0;
        cmd_ch.write_value = '0;
        cmd_ch.param_u     = '0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_CURVE_ORDER;
        cfg_ch.data        = '0;
        cmd_taken          = 1'b0;
        gap_pct            = 0;
        stall_pct          = 0;
        error_count        = 0;
        shadow_order       = CURVE_ORDER_RST;
        shadow_dims        = DIMS_IN_USE_RST;
        foreach (shadow_points[i])
            shadow_points[i] = '0;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration over a cleared store.
        push_eval(32768);
        wait_idle();

        // Highest order and full dimensions with extreme coordinates and every
        // way of clamping u.
        write_register(REG_CURVE_ORDER, 3'd7);
        write_register(REG_DIMS_IN_USE, 3'd4);
        push_write(0, 0, COORD_MAX);
        push_write(7, 0, COORD_MIN);
        push_write(0, 3, COORD_MIN);
        push_write(7, 3, COORD_MAX);
        push_write(3, 1, -1);
        push_write(4, 2, 1);
        push_eval(0);
        push_eval(U_FULL);
        push_eval(32768);
        push_eval(-131072);
        push_eval(131071);
        push_eval(1);
        push_eval(U_FULL - 1);
        wait_idle();

        // Writes past the order or the dimension count are dropped.
        write_register(REG_CURVE_ORDER, 3'd2);
        write_register(REG_DIMS_IN_USE, 3'd1);
        push_write(3, 0, coord_t'($urandom()));
        push_write(0, 1, coord_t'($urandom()));
        push_write(2, 0, coord_t'($urandom()));
        push_eval(20000);
        wait_idle();

        // No dimensions: writes are dropped and evaluation returns nothing.
        write_register(REG_DIMS_IN_USE, 3'd0);
        push_write(0, 0, coord_t'($urandom()));
        push_eval(50000);
        wait_idle();

        // Undecoded registers, then a dimension count above the maximum.
        write_register(REG_SPARE_2, 3'd5);
        write_register(REG_SPARE_3, 3'd1);
        write_register(REG_CURVE_ORDER, 3'd7);
        write_register(REG_DIMS_IN_USE, 3'd7);
        push_eval(40000);
        wait_idle();

        // Random curves: each phase loads points and evaluates them.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  order_sel = 7; dims_sel = 4; end
                1: begin
                    gap_pct = 56; stall_pct = 0;
                    order_sel = $urandom_range(1, 6);
                    dims_sel  = $urandom_range(1, 4);
                end
                2: begin
                    gap_pct = 0; stall_pct = 56;
                    order_sel = $urandom_range(0, 7);
                    dims_sel  = $urandom_range(1, 7);
                end
                default: begin gap_pct = 20; stall_pct = 20; order_sel = 7; dims_sel = 3; end
            endcase
            dims_eff = (dims_sel > MAX_DIMS) ? MAX_DIMS : dims_sel;
            write_register(REG_CURVE_ORDER, CFG_DAT_W'(order_sel));
            write_register(REG_DIMS_IN_USE, CFG_DAT_W'(dims_sel));

            for (int n = 0; n < 20; n++)
            begin
                if (n < 8 || $urandom_range(3) == 0)
                begin
                    // Mostly in-range points, now and then a dropped write.
                    pt = ($urandom_range(99) < 85) ? $urandom_range(0, order_sel)
                                                   : $urandom_range(0, 7);
                    ax = ($urandom_range(99) < 85) ? $urandom_range(0, dims_eff - 1)
                                                   : $urandom_range(0, 3);
                    case ($urandom_range(7))
                        0: value = COORD_MAX;
                        1: value = COORD_MIN;
                        2: value = '0;
                        default: value = coord_t'($urandom());
                    endcase
                    push_write(pt, ax, value);
                end
                else if ($urandom_range(3) != 0)
                begin
                    push_eval($urandom_range(0, U_FULL));
                end
                else
                begin
                    push_eval($urandom());
                end
            end
            wait_idle();
        end

        if (error_count == 0 && awaited_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
